// ===== rtl/swqf_pkg.sv =====
// Shared types, constants and the fit program for the quadratic window fit.
`timescale 1ns / 1ps
package swqf_pkg;

   localparam int BIG_W     = 320;
   localparam int REG_AW    = 5;
   localparam int REG_DEPTH = 32;
   localparam int EST_W     = 48;
   localparam int DIV_CW    = $clog2(BIG_W);
   localparam int PC_W      = 7;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOT_FULL = 2'd1;
   localparam logic [1:0] STAT_STALE    = 2'd2;
   localparam logic [1:0] STAT_SINGULAR = 2'd3;

   typedef enum logic [3:0] {
      OP_CLR, OP_LDN, OP_AGE, OP_Y, OP_ADD, OP_SUB, OP_MUL,
      OP_SHL16, OP_SHL33, OP_DIV, OP_CHK, OP_LOOP, OP_END
   } op_type;

   // register file slots
   localparam logic [REG_AW-1:0] R_Z   = 5'd0;
   localparam logic [REG_AW-1:0] R_S0  = 5'd1;
   localparam logic [REG_AW-1:0] R_S1  = 5'd2;
   localparam logic [REG_AW-1:0] R_S2  = 5'd3;
   localparam logic [REG_AW-1:0] R_S3  = 5'd4;
   localparam logic [REG_AW-1:0] R_S4  = 5'd5;
   localparam logic [REG_AW-1:0] R_B0  = 5'd6;
   localparam logic [REG_AW-1:0] R_B1  = 5'd7;
   localparam logic [REG_AW-1:0] R_B2  = 5'd8;
   localparam logic [REG_AW-1:0] R_AGE = 5'd9;
   localparam logic [REG_AW-1:0] R_Y   = 5'd10;
   localparam logic [REG_AW-1:0] R_P   = 5'd11;
   localparam logic [REG_AW-1:0] R_T   = 5'd12;
   localparam logic [REG_AW-1:0] R_U   = 5'd13;
   localparam logic [REG_AW-1:0] R_C00 = 5'd14;
   localparam logic [REG_AW-1:0] R_C01 = 5'd15;
   localparam logic [REG_AW-1:0] R_C02 = 5'd16;
   localparam logic [REG_AW-1:0] R_A11 = 5'd17;
   localparam logic [REG_AW-1:0] R_A21 = 5'd18;
   localparam logic [REG_AW-1:0] R_A22 = 5'd19;
   localparam logic [REG_AW-1:0] R_DEN = 5'd20;
   localparam logic [REG_AW-1:0] R_N   = 5'd21;

   // estimate slots, carried in the destination field of a divide
   localparam logic [REG_AW-1:0] EST_POS = 5'd0;
   localparam logic [REG_AW-1:0] EST_VEL = 5'd1;
   localparam logic [REG_AW-1:0] EST_ACC = 5'd2;

   localparam logic [PC_W-1:0] LOOP_START = 7'd9;

   typedef struct packed {
      op_type            op;
      logic [REG_AW-1:0] dst;
      logic [REG_AW-1:0] a;
      logic [REG_AW-1:0] b;
   } instr_type;

   typedef struct packed {
      logic              go;
      op_type            op;
      logic [REG_AW-1:0] dst;
      logic [REG_AW-1:0] a;
      logic [REG_AW-1:0] b;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic zero;
   } stat_type;

   function automatic instr_type mk(input op_type op, input logic [REG_AW-1:0] d,
                                    input logic [REG_AW-1:0] a,
                                    input logic [REG_AW-1:0] b);
      instr_type r;
      r.op  = op;
      r.dst = d;
      r.a   = a;
      r.b   = b;
      return r;
   endfunction

   // Normal equations of the fit; cofactors of the symmetric Gram matrix
   // are shared between the determinant and the three numerators.
   function automatic instr_type swqf_program(input logic [PC_W-1:0] pc);
      instr_type r;
      unique case (pc)
         7'd0:  r = mk(OP_CLR,   R_Z,   R_Z,   R_Z);
         7'd1:  r = mk(OP_CLR,   R_S1,  R_Z,   R_Z);
         7'd2:  r = mk(OP_CLR,   R_S2,  R_Z,   R_Z);
         7'd3:  r = mk(OP_CLR,   R_S3,  R_Z,   R_Z);
         7'd4:  r = mk(OP_CLR,   R_S4,  R_Z,   R_Z);
         7'd5:  r = mk(OP_CLR,   R_B0,  R_Z,   R_Z);
         7'd6:  r = mk(OP_CLR,   R_B1,  R_Z,   R_Z);
         7'd7:  r = mk(OP_CLR,   R_B2,  R_Z,   R_Z);
         7'd8:  r = mk(OP_LDN,   R_S0,  R_Z,   R_Z);
         7'd9:  r = mk(OP_AGE,   R_AGE, R_Z,   R_Z);
         7'd10: r = mk(OP_Y,     R_Y,   R_Z,   R_Z);
         7'd11: r = mk(OP_ADD,   R_S1,  R_S1,  R_AGE);
         7'd12: r = mk(OP_MUL,   R_P,   R_AGE, R_AGE);
         7'd13: r = mk(OP_ADD,   R_S2,  R_S2,  R_P);
         7'd14: r = mk(OP_MUL,   R_P,   R_P,   R_AGE);
         7'd15: r = mk(OP_ADD,   R_S3,  R_S3,  R_P);
         7'd16: r = mk(OP_MUL,   R_P,   R_P,   R_AGE);
         7'd17: r = mk(OP_ADD,   R_S4,  R_S4,  R_P);
         7'd18: r = mk(OP_ADD,   R_B0,  R_B0,  R_Y);
         7'd19: r = mk(OP_MUL,   R_T,   R_Y,   R_AGE);
         7'd20: r = mk(OP_ADD,   R_B1,  R_B1,  R_T);
         7'd21: r = mk(OP_MUL,   R_T,   R_T,   R_AGE);
         7'd22: r = mk(OP_ADD,   R_B2,  R_B2,  R_T);
         7'd23: r = mk(OP_LOOP,  R_Z,   R_Z,   R_Z);
         7'd24: r = mk(OP_MUL,   R_T,   R_S4,  R_S2);
         7'd25: r = mk(OP_MUL,   R_U,   R_S3,  R_S3);
         7'd26: r = mk(OP_SUB,   R_C00, R_T,   R_U);
         7'd27: r = mk(OP_MUL,   R_T,   R_S4,  R_S1);
         7'd28: r = mk(OP_MUL,   R_U,   R_S3,  R_S2);
         7'd29: r = mk(OP_SUB,   R_C01, R_T,   R_U);
         7'd30: r = mk(OP_MUL,   R_T,   R_S3,  R_S1);
         7'd31: r = mk(OP_MUL,   R_U,   R_S2,  R_S2);
         7'd32: r = mk(OP_SUB,   R_C02, R_T,   R_U);
         7'd33: r = mk(OP_MUL,   R_T,   R_S4,  R_S0);
         7'd34: r = mk(OP_MUL,   R_U,   R_S2,  R_S2);
         7'd35: r = mk(OP_SUB,   R_A11, R_T,   R_U);
         7'd36: r = mk(OP_MUL,   R_T,   R_S3,  R_S0);
         7'd37: r = mk(OP_MUL,   R_U,   R_S2,  R_S1);
         7'd38: r = mk(OP_SUB,   R_A21, R_T,   R_U);
         7'd39: r = mk(OP_MUL,   R_T,   R_S2,  R_S0);
         7'd40: r = mk(OP_MUL,   R_U,   R_S1,  R_S1);
         7'd41: r = mk(OP_SUB,   R_A22, R_T,   R_U);
         7'd42: r = mk(OP_MUL,   R_T,   R_C00, R_S0);
         7'd43: r = mk(OP_MUL,   R_U,   R_C01, R_S1);
         7'd44: r = mk(OP_SUB,   R_T,   R_T,   R_U);
         7'd45: r = mk(OP_MUL,   R_U,   R_C02, R_S2);
         7'd46: r = mk(OP_ADD,   R_DEN, R_T,   R_U);
         7'd47: r = mk(OP_CHK,   R_Z,   R_Z,   R_Z);
         7'd48: r = mk(OP_MUL,   R_T,   R_C00, R_B0);
         7'd49: r = mk(OP_MUL,   R_U,   R_C01, R_B1);
         7'd50: r = mk(OP_SUB,   R_T,   R_T,   R_U);
         7'd51: r = mk(OP_MUL,   R_U,   R_C02, R_B2);
         7'd52: r = mk(OP_ADD,   R_N,   R_T,   R_U);
         7'd53: r = mk(OP_DIV,   EST_POS, R_N, R_DEN);
         7'd54: r = mk(OP_MUL,   R_T,   R_A11, R_B1);
         7'd55: r = mk(OP_MUL,   R_U,   R_C01, R_B0);
         7'd56: r = mk(OP_SUB,   R_T,   R_T,   R_U);
         7'd57: r = mk(OP_MUL,   R_U,   R_A21, R_B2);
         7'd58: r = mk(OP_SUB,   R_N,   R_T,   R_U);
         7'd59: r = mk(OP_SHL16, R_N,   R_N,   R_Z);
         7'd60: r = mk(OP_SUB,   R_N,   R_Z,   R_N);
         7'd61: r = mk(OP_DIV,   EST_VEL, R_N, R_DEN);
         7'd62: r = mk(OP_MUL,   R_T,   R_C02, R_B0);
         7'd63: r = mk(OP_MUL,   R_U,   R_A21, R_B1);
         7'd64: r = mk(OP_SUB,   R_T,   R_T,   R_U);
         7'd65: r = mk(OP_MUL,   R_U,   R_A22, R_B2);
         7'd66: r = mk(OP_ADD,   R_N,   R_T,   R_U);
         7'd67: r = mk(OP_SHL33, R_N,   R_N,   R_Z);
         7'd68: r = mk(OP_DIV,   EST_ACC, R_N, R_DEN);
         default: r = mk(OP_END, R_Z,   R_Z,   R_Z);
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/swqf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module swqf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/swqf_datapath.sv =====
// Datapath: sample ring, big-number register file, serial multiplier and divider.
`timescale 1ns / 1ps
module swqf_datapath import swqf_pkg::*; #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cmd_type                         cmd,
   input  logic                            samp_wr_en,
   input  logic [$clog2(WINDOW_DEPTH)-1:0] samp_wr_idx,
   input  logic [$clog2(WINDOW_DEPTH)-1:0] samp_rd_idx,
   input  logic [31:0]                     sample_value,
   input  logic [31:0]                     sample_time,
   output stat_type                        stat,
   output logic [EST_W-1:0]                est_pos,
   output logic [EST_W-1:0]                est_vel,
   output logic [EST_W-1:0]                est_acc,
   output logic                            saturated
);

   typedef enum logic [4:0] {
      DV_IDLE = 5'b00001,
      DV_ABS  = 5'b00010,
      DV_FORM = 5'b00100,
      DV_ITER = 5'b01000,
      DV_FIN  = 5'b10000
   } div_state_type;

   logic [63:0]       samp_q;
   logic [BIG_W-1:0]  ra, rb;
   logic              wr_en;
   logic [BIG_W-1:0]  wr_data;
   logic [BIG_W-1:0]  alu;
   logic [32:0]       age;
   logic              is_single;

   logic [31:0]       tnew_ff;
   logic              zero_ff;

   logic              mul_run_ff;
   logic [BIG_W-1:0]  acc_ff, mcand_ff, mplier_ff;
   logic              mul_zero, mul_ones, mul_fin;
   logic [BIG_W-1:0]  mul_sum;

   div_state_type     dv_ff;
   logic [BIG_W-1:0]  t_ff, d_ff, rem_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic [EST_W-1:0]  q_ff;
   logic              big_ff, neg_ff;
   logic [REG_AW-1:0] idx_ff;
   logic [BIG_W:0]    r_shift, trial;
   logic              ge;
   logic              sat_now;
   logic [EST_W-1:0]  est_now;

   logic [EST_W-1:0]  est_pos_ff, est_vel_ff, est_acc_ff;
   logic              sat_ff;

   swqf_ram #(.WIDTH(64), .DEPTH(WINDOW_DEPTH)) u_samples (
      .clock   (clock),
      .wr_en   (samp_wr_en),
      .wr_addr (samp_wr_idx),
      .wr_data ({sample_time, sample_value}),
      .rd_addr (samp_rd_idx),
      .rd_data (samp_q)
   );

   // two copies of the register file give two read ports
   swqf_ram #(.WIDTH(BIG_W), .DEPTH(REG_DEPTH)) u_regs_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd.dst),
      .wr_data (wr_data),
      .rd_addr (cmd.a),
      .rd_data (ra)
   );

   swqf_ram #(.WIDTH(BIG_W), .DEPTH(REG_DEPTH)) u_regs_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd.dst),
      .wr_data (wr_data),
      .rd_addr (cmd.b),
      .rd_data (rb)
   );

   assign age = {1'b0, tnew_ff} - {1'b0, samp_q[63:32]};

   always_comb begin
      alu = '0;
      unique case (cmd.op)
         OP_CLR:   alu = '0;
         OP_LDN:   alu = BIG_W'(WINDOW_DEPTH);
         OP_AGE:   alu = {{(BIG_W-33){age[32]}}, age};
         OP_Y:     alu = {{(BIG_W-32){samp_q[31]}}, samp_q[31:0]};
         OP_ADD:   alu = ra + rb;
         OP_SUB:   alu = ra - rb;
         OP_SHL16: alu = ra << 16;
         OP_SHL33: alu = ra << 33;
         default:  alu = '0;
      endcase
   end

   assign is_single = (cmd.op == OP_CLR) || (cmd.op == OP_LDN) || (cmd.op == OP_AGE) ||
                      (cmd.op == OP_Y) || (cmd.op == OP_ADD) || (cmd.op == OP_SUB) ||
                      (cmd.op == OP_SHL16) || (cmd.op == OP_SHL33);

   // Shift-add multiply; stop once the remaining multiplier is all sign bits.
   assign mul_zero = (mplier_ff == '0);
   assign mul_ones = &mplier_ff;
   assign mul_fin  = mul_run_ff & (mul_zero | mul_ones);
   assign mul_sum  = acc_ff + (mul_ones ? ~mcand_ff : mcand_ff) + BIG_W'(mul_ones);

   assign wr_en   = (cmd.go & is_single) | mul_fin;
   assign wr_data = mul_fin ? (mul_ones ? mul_sum : acc_ff) : alu;

   // restoring divide step
   assign r_shift = {rem_ff, t_ff[BIG_W-1]};
   assign trial   = r_shift - {1'b0, d_ff};
   assign ge      = ~trial[BIG_W];

   always_comb begin
      if (neg_ff) begin
         sat_now = big_ff | (q_ff[EST_W-1] & (|q_ff[EST_W-2:0]));
         est_now = sat_now ? {1'b1, {(EST_W-1){1'b0}}} : (EST_W'(0) - q_ff);
      end else begin
         sat_now = big_ff | q_ff[EST_W-1];
         est_now = sat_now ? {1'b0, {(EST_W-1){1'b1}}} : q_ff;
      end
   end

   assign stat.done = (cmd.go & is_single) | mul_fin | (dv_ff == DV_FIN);
   assign stat.zero = zero_ff;

   always_ff @(posedge clock) begin
      if (samp_wr_en) begin
         tnew_ff <= sample_time;
      end
      if (reset) begin
         zero_ff <= 1'b0;
      end else if (wr_en) begin
         zero_ff <= (wr_data == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_run_ff <= 1'b0;
      end else if (cmd.go && cmd.op == OP_MUL) begin
         mul_run_ff <= 1'b1;
      end else if (mul_fin) begin
         mul_run_ff <= 1'b0;
      end
      if (cmd.go && cmd.op == OP_MUL) begin
         acc_ff    <= '0;
         mcand_ff  <= ra;
         mplier_ff <= rb;
      end else if (mul_run_ff && !mul_fin) begin
         if (mplier_ff[0]) begin
            acc_ff <= mul_sum;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= {mplier_ff[BIG_W-1], mplier_ff[BIG_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= DV_IDLE;
      end else begin
         unique case (dv_ff)
            DV_IDLE: if (cmd.go && cmd.op == OP_DIV) begin
               dv_ff <= DV_ABS;
            end
            DV_ABS:  dv_ff <= DV_FORM;
            DV_FORM: dv_ff <= DV_ITER;
            DV_ITER: if (cnt_ff == '0) begin
               dv_ff <= DV_FIN;
            end
            DV_FIN:  dv_ff <= DV_IDLE;
            default: dv_ff <= DV_IDLE;
         endcase
      end
      unique case (dv_ff)
         DV_IDLE: if (cmd.go && cmd.op == OP_DIV) begin
            t_ff   <= ra;
            d_ff   <= rb;
            neg_ff <= ra[BIG_W-1] ^ rb[BIG_W-1];
            idx_ff <= cmd.dst;
         end
         DV_ABS: begin
            t_ff <= t_ff[BIG_W-1] ? ('0 - t_ff) : t_ff;
            d_ff <= d_ff[BIG_W-1] ? ('0 - d_ff) : d_ff;
         end
         DV_FORM: begin
            t_ff   <= (t_ff << 1) + d_ff;
            d_ff   <= d_ff << 1;
            rem_ff <= '0;
            cnt_ff <= DIV_CW'(BIG_W - 1);
            q_ff   <= '0;
            big_ff <= 1'b0;
         end
         DV_ITER: begin
            rem_ff <= ge ? trial[BIG_W-1:0] : r_shift[BIG_W-1:0];
            t_ff   <= t_ff << 1;
            q_ff   <= {q_ff[EST_W-2:0], ge};
            big_ff <= big_ff | q_ff[EST_W-1];
            cnt_ff <= cnt_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.go && cmd.op == OP_CLR) begin
         sat_ff <= 1'b0;
      end else if (dv_ff == DV_FIN) begin
         sat_ff <= sat_ff | sat_now;
      end
      if (dv_ff == DV_FIN) begin
         if (idx_ff == EST_POS) begin
            est_pos_ff <= est_now;
         end
         if (idx_ff == EST_VEL) begin
            est_vel_ff <= est_now;
         end
         if (idx_ff == EST_ACC) begin
            est_acc_ff <= est_now;
         end
      end
   end

   assign est_pos   = est_pos_ff;
   assign est_vel   = est_vel_ff;
   assign est_acc   = est_acc_ff;
   assign saturated = sat_ff;

endmodule

// ===== rtl/swqf_ctrl.sv =====
// Controller: ring bookkeeping, item decisions and the fit program sequencer.
`timescale 1ns / 1ps
module swqf_ctrl import swqf_pkg::*; #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [31:0]                     sample_time,
   output cmd_type                         cmd,
   input  stat_type                        stat,
   output logic                            samp_wr_en,
   output logic [$clog2(WINDOW_DEPTH)-1:0] samp_wr_idx,
   output logic [$clog2(WINDOW_DEPTH)-1:0] samp_rd_idx,
   input  logic                            out_ready,
   output logic                            out_load,
   output logic                            out_est_valid,
   output logic [1:0]                      out_status
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type       state_ff;
   logic [IDX_W-1:0] newest_ff, k_ff, idx_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [31:0]      last_time_ff;
   logic [PC_W-1:0]  pc_ff;
   logic             go_ff;
   logic             est_valid_ff;
   logic [1:0]       status_ff;
   logic             accept;
   instr_type        instr;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign instr     = swqf_program(pc_ff);

   always_comb begin
      idx_in  = newest_ff;
      held_in = held_ff;
      if (held_ff != '0) begin
         idx_in = (newest_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : newest_ff + 1'b1;
      end
      if (held_ff != CNT_W'(WINDOW_DEPTH)) begin
         held_in = held_ff + 1'b1;
      end
   end

   assign samp_wr_en  = accept;
   assign samp_wr_idx = idx_in;
   assign samp_rd_idx = k_ff;

   assign cmd.go  = go_ff;
   assign cmd.op  = instr.op;
   assign cmd.dst = instr.dst;
   assign cmd.a   = instr.a;
   assign cmd.b   = instr.b;

   assign out_load      = (state_ff == ST_DONE) & out_ready;
   assign out_est_valid = est_valid_ff;
   assign out_status    = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         newest_ff    <= '0;
         held_ff      <= '0;
         last_time_ff <= '0;
         pc_ff        <= '0;
         k_ff         <= '0;
         go_ff        <= 1'b0;
         est_valid_ff <= 1'b0;
         status_ff    <= STAT_OK;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               newest_ff    <= idx_in;
               held_ff      <= held_in;
               est_valid_ff <= 1'b0;
               if (held_in != CNT_W'(WINDOW_DEPTH)) begin
                  status_ff <= STAT_NOT_FULL;
                  state_ff  <= ST_DONE;
               end else if (sample_time <= last_time_ff) begin
                  status_ff <= STAT_STALE;
                  state_ff  <= ST_DONE;
               end else begin
                  last_time_ff <= sample_time;
                  pc_ff        <= '0;
                  k_ff         <= '0;
                  state_ff     <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               unique case (instr.op)
                  OP_CHK: if (stat.zero) begin
                     status_ff <= STAT_SINGULAR;
                     state_ff  <= ST_DONE;
                  end else begin
                     pc_ff <= pc_ff + 1'b1;
                  end
                  OP_LOOP: if (k_ff == IDX_W'(WINDOW_DEPTH - 1)) begin
                     pc_ff <= pc_ff + 1'b1;
                  end else begin
                     k_ff  <= k_ff + 1'b1;
                     pc_ff <= LOOP_START;
                  end
                  OP_END: begin
                     status_ff    <= STAT_OK;
                     est_valid_ff <= 1'b1;
                     state_ff     <= ST_DONE;
                  end
                  default: begin
                     go_ff    <= 1'b1;
                     state_ff <= ST_EXEC;
                  end
               endcase
            end
            ST_EXEC: begin
               go_ff <= 1'b0;
               if (stat.done) begin
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= ST_FETCH;
               end
            end
            ST_DONE: if (out_ready) begin
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/sliding_window_quadratic_fit_top.sv =====
// Top level of the sliding-window quadratic least-squares fit.
`timescale 1ns / 1ps
// Usage:
//   req channel: one item per sample, {sample_time, sample_value}. The sample
//   goes into a ring of WINDOW_DEPTH entries, replacing the oldest one.
//   rsp channel: exactly one item per sample, in order. tuser carries
//   estimate_valid and status; tdata carries position (signed Q48.0),
//   velocity (signed Q32.16) and acceleration (signed Q16.32), all rounded
//   and saturated, and the saturated flag, all zero when no estimate was made.
//   Flow: an item that makes no estimate (window not full or timestamp not
//   newer) goes from accept to the done state, and from there into the output
//   register that drives rsp_tvalid. A fit walks a stored program on one shared
//   320-bit shift-add multiplier (one multiplier bit per cycle, stopping at
//   the sign bits) and a restoring divider (320 steps per estimate); its run
//   time grows with WINDOW_DEPTH and with the bit lengths of the ages.
//   One item is worked at a time; req_tready is high only while idle.
//   Stall: the result sits in an output register; a new item is taken while
//   it waits, and the next result holds back until the register frees.
//   Reset: synchronous; clears ring bookkeeping and last estimate time.
//   The sample ring needs no clearing: a fit runs only once it is full.
module sliding_window_quadratic_fit_top import swqf_pkg::*; #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // [31:0] sample_value, [63:32] sample_time
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // [47:0] position_est, [95:48] velocity_est,
                                     // [143:96] accel_est, [144] saturated, zero pad
   output logic [2:0]   rsp_tuser    // [0] estimate_valid, [2:1] status
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);

   cmd_type          cmd;
   stat_type         stat;
   logic             samp_wr_en;
   logic [IDX_W-1:0] samp_wr_idx, samp_rd_idx;
   logic             out_ready, out_load, out_est_valid;
   logic [1:0]       out_status;
   logic [EST_W-1:0] est_pos, est_vel, est_acc;
   logic             saturated;

   logic             rsp_valid_ff;
   logic [151:0]     rsp_data_ff;
   logic [2:0]       rsp_user_ff;

   swqf_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .sample_time   (req_tdata[63:32]),
      .cmd           (cmd),
      .stat          (stat),
      .samp_wr_en    (samp_wr_en),
      .samp_wr_idx   (samp_wr_idx),
      .samp_rd_idx   (samp_rd_idx),
      .out_ready     (out_ready),
      .out_load      (out_load),
      .out_est_valid (out_est_valid),
      .out_status    (out_status)
   );

   swqf_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .samp_wr_en   (samp_wr_en),
      .samp_wr_idx  (samp_wr_idx),
      .samp_rd_idx  (samp_rd_idx),
      .sample_value (req_tdata[31:0]),
      .sample_time  (req_tdata[63:32]),
      .stat         (stat),
      .est_pos      (est_pos),
      .est_vel      (est_vel),
      .est_acc      (est_acc),
      .saturated    (saturated)
   );

   // Output register frees when empty or when the current item is taken.
   assign out_ready = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_user_ff <= {out_status, out_est_valid};
         // drop the estimate fields when no fit was made
         rsp_data_ff <= out_est_valid ? {7'd0, saturated, est_acc, est_vel, est_pos} : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
